@@ hdl/hc2_pkg.sv @@
`timescale 1ns / 1ps

package hc2_pkg;

    localparam int unsigned LetterW = 5;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 5;

    localparam logic [LetterW-1:0] NUM_LETTERS = 5'd26;
    localparam logic [LetterW-1:0] PAD_LETTER = 5'd25;

    localparam logic [CfgIdxW-1:0] CFG_KEY_R0C0 = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY_R0C1 = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_KEY_R1C0 = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_KEY_R1C1 = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_DECRYPT = 3'd4;

    typedef struct packed {
        logic [LetterW-1:0] letter;
        logic               is_last;
    } t_in;

    typedef struct packed {
        logic [LetterW-1:0] first_letter;
        logic [LetterW-1:0] second_letter;
        logic               last_pair;
        logic               key_error;
        logic               odd_dropped;
    } t_out;

    // fold a 5-bit value into 0..25
    function automatic logic [LetterW-1:0] red26(input logic [LetterW-1:0] x);
        red26 = (x >= NUM_LETTERS) ? x - NUM_LETTERS : x;
    endfunction

    // full 10-bit product of two 5-bit values, widened to 11 bits
    function automatic logic [10:0] mul5x5(input logic [LetterW-1:0] a,
                                           input logic [LetterW-1:0] b);
        mul5x5 = {6'd0, a} * {6'd0, b};
    endfunction

    // x mod 26 for x up to 1250: quotient by reciprocal 2521/65536 is exact in that range
    function automatic logic [LetterW-1:0] mod26(input logic [10:0] x);
        logic [22:0] prod;
        logic [6:0]  quot;
        logic [10:0] rem;
        prod = {12'd0, x} * 23'd2521;
        quot = prod[22:16];
        rem  = x - ({4'd0, quot} * 11'd26);
        mod26 = rem[LetterW-1:0];
    endfunction

    // additive inverse mod 26 of a value already in 0..25
    function automatic logic [LetterW-1:0] neg26(input logic [LetterW-1:0] x);
        neg26 = (x == '0) ? '0 : NUM_LETTERS - x;
    endfunction

    // multiplicative inverse mod 26, zero where none exists
    function automatic logic [LetterW-1:0] inv26(input logic [LetterW-1:0] x);
        case (x)
            5'd1:    inv26 = 5'd1;
            5'd3:    inv26 = 5'd9;
            5'd5:    inv26 = 5'd21;
            5'd7:    inv26 = 5'd15;
            5'd9:    inv26 = 5'd3;
            5'd11:   inv26 = 5'd19;
            5'd15:   inv26 = 5'd7;
            5'd17:   inv26 = 5'd23;
            5'd19:   inv26 = 5'd11;
            5'd21:   inv26 = 5'd5;
            5'd23:   inv26 = 5'd17;
            5'd25:   inv26 = 5'd25;
            default: inv26 = 5'd0;
        endcase
    endfunction

endpackage

@@ hdl/hill_cipher_2x2_mod26.sv @@
`timescale 1ns / 1ps

// 2x2 Hill cipher over letter indices 0..25. Letters enter one per cycle while not stalled and
// are paired in arrival order; each completed pair (or an unpaired final letter) yields one
// result. A three-stage register pipeline does the work: pairing and the key determinant
// inverse, then the working matrix (key or inverse key), then the two multiply-adds mod 26
// into the output register. Stages fill any gap, so input is held off only when all three
// hold results and the output is stalled. Key registers are read live as a pair moves
// through the stages, so write them only with no pair in flight; a held first letter may
// wait across a write.
module hill_cipher_2x2_mod26
    import hc2_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in                 i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out                o_out_data,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    logic [LetterW-1:0] r_key_a, r_key_b, r_key_c, r_key_d;
    logic               r_decrypt;
    logic [LetterW-1:0] r_held;
    logic               r_holding;

    logic [LetterW-1:0] key_a, key_b, key_c, key_d;
    logic [LetterW-1:0] prod_ad, prod_bc;
    logic [LetterW-1:0] n_det;
    logic               in_acc, emit;
    logic [LetterW-1:0] in_letter;
    logic               s1_free, s2_free, s3_free;

    // stage 1: pair and determinant inverse
    logic               r1_v;
    logic [LetterW-1:0] r1_p0, r1_p1, r1_inv;
    logic               r1_dec, r1_last, r1_drop;
    logic [LetterW-1:0] n1_p0, n1_p1;
    logic               n1_drop;

    // stage 2: working matrix
    logic               r2_v;
    logic [LetterW-1:0] r2_p0, r2_p1, r2_m00, r2_m01, r2_m10, r2_m11;
    logic               r2_kerr, r2_last, r2_drop;
    logic [LetterW-1:0] n2_m00, n2_m01, n2_m10, n2_m11;

    // stage 3: output register
    logic               r3_v;
    t_out               r3_out;
    logic [10:0]        n3_sum0, n3_sum1;

    assign key_a = red26(r_key_a);
    assign key_b = red26(r_key_b);
    assign key_c = red26(r_key_c);
    assign key_d = red26(r_key_d);

    assign s3_free = !r3_v || !i_out_stall;
    assign s2_free = !r2_v || s3_free;
    assign s1_free = !r1_v || s2_free;

    assign o_in_stall  = !s1_free;
    assign in_acc      = i_in_valid && s1_free;
    assign in_letter   = red26(i_in_data.letter);
    assign emit        = r_holding || i_in_data.is_last;
    assign o_out_valid = r3_v;
    assign o_out_data  = r3_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a   <= 5'd1;
            r_key_b   <= 5'd0;
            r_key_c   <= 5'd0;
            r_key_d   <= 5'd1;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_R0C0: r_key_a <= i_cfg_data;
                CFG_KEY_R0C1: r_key_b <= i_cfg_data;
                CFG_KEY_R1C0: r_key_c <= i_cfg_data;
                CFG_KEY_R1C1: r_key_d <= i_cfg_data;
                CFG_DECRYPT:  r_decrypt <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pairing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding <= 1'b0;
            r_held    <= '0;
        end else if (in_acc) begin
            if (r_holding) begin
                r_holding <= 1'b0;
                r_held    <= '0;
            end else if (!i_in_data.is_last) begin
                r_holding <= 1'b1;
                r_held    <= in_letter;
            end
        end
    end

    always_comb begin
        prod_ad = mod26(mul5x5(key_a, key_d));
        prod_bc = mod26(mul5x5(key_b, key_c));
        n_det   = (prod_ad >= prod_bc) ? prod_ad - prod_bc : prod_ad + NUM_LETTERS - prod_bc;
        n1_drop = 1'b0;
        if (r_holding) begin
            n1_p0 = r_held;
            n1_p1 = in_letter;
        end else if (r_decrypt) begin
            // unpaired final letter in decrypt: drop it
            n1_p0   = '0;
            n1_p1   = '0;
            n1_drop = 1'b1;
        end else begin
            n1_p0 = in_letter;
            n1_p1 = PAD_LETTER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (s1_free) begin
            r1_v <= in_acc && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r1_p0   <= n1_p0;
            r1_p1   <= n1_p1;
            r1_inv  <= inv26(n_det);
            r1_dec  <= r_decrypt;
            r1_last <= i_in_data.is_last;
            r1_drop <= n1_drop;
        end
    end

    always_comb begin
        if (r1_dec) begin
            n2_m00 = mod26(mul5x5(key_d, r1_inv));
            n2_m01 = neg26(mod26(mul5x5(key_b, r1_inv)));
            n2_m10 = neg26(mod26(mul5x5(key_c, r1_inv)));
            n2_m11 = mod26(mul5x5(key_a, r1_inv));
        end else begin
            n2_m00 = key_a;
            n2_m01 = key_b;
            n2_m10 = key_c;
            n2_m11 = key_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (s2_free) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r2_p0   <= r1_p0;
            r2_p1   <= r1_p1;
            r2_m00  <= n2_m00;
            r2_m01  <= n2_m01;
            r2_m10  <= n2_m10;
            r2_m11  <= n2_m11;
            r2_kerr <= (r1_inv == '0);
            r2_last <= r1_last;
            r2_drop <= r1_drop;
        end
    end

    assign n3_sum0 = mul5x5(r2_p0, r2_m00) + mul5x5(r2_p1, r2_m10);
    assign n3_sum1 = mul5x5(r2_p0, r2_m01) + mul5x5(r2_p1, r2_m11);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (s3_free) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free) begin
            // singular key: zero the letters
            r3_out.first_letter  <= r2_kerr ? '0 : mod26(n3_sum0);
            r3_out.second_letter <= r2_kerr ? '0 : mod26(n3_sum1);
            r3_out.last_pair     <= r2_last;
            r3_out.key_error     <= r2_kerr;
            r3_out.odd_dropped   <= r2_drop;
        end
    end

    a_letters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.first_letter < NUM_LETTERS)
                     && (o_out_data.second_letter < NUM_LETTERS))
        else $error("result letter out of range");

    a_key_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.key_error) |->
            (o_out_data.first_letter == '0) && (o_out_data.second_letter == '0))
        else $error("singular key result carries letters");

    a_drop_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.odd_dropped) |->
            o_out_data.last_pair && (o_out_data.first_letter == '0)
            && (o_out_data.second_letter == '0))
        else $error("dropped letter result malformed");

    a_hold_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_holding && !i_in_data.is_last) |=> r_holding)
        else $error("first letter of pair not held");

    a_pair_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_holding) |=> (!r_holding && r1_v))
        else $error("completed pair did not enter pipeline");

endmodule
